[rtl/psp_pkg.sv]
// Shared types, constants and tables of the Phong specular pipeline.
package psp_pkg;

  localparam int CW        = 16;  // color and register width
  localparam int LOG_F     = 24;  // fraction bits of the log / exponent
  localparam int DS_STEPS  = 30;  // num / |N|^2 and isqrt, one bit per stage
  localparam int CQ_STEPS  = 31;  // cosine divide, one bit per stage
  localparam int LOG_STEPS = LOG_F;
  localparam int POW_STEPS = LOG_F;

  localparam logic [30:0] ONE30 = 31'h4000_0000;

  typedef enum logic [2:0] {
    REG_MAT_R     = 3'd0,
    REG_MAT_G     = 3'd1,
    REG_MAT_B     = 3'd2,
    REG_SHININESS = 3'd3,
    REG_SPEC_GAIN = 3'd4
  } reg_idx_e;

  typedef logic [2:0][CW-1:0] rgb_t;  // [0] red, [1] green, [2] blue

  // num / A division and isqrt(|L|^2 |V|^2), side by side
  typedef struct packed {
    logic        vld;
    logic        kill;
    logic [59:0] rem;
    logic [29:0] dvs;
    logic [29:0] q;
    logic [59:0] sv;
    logic [59:0] sr;
    rgb_t        light;
  } ds_t;

  // cq = (t << 30) / D
  typedef struct packed {
    logic        vld;
    logic        kill;
    logic        sat;
    logic [60:0] rem;
    logic [29:0] dvs;
    logic [30:0] q;
    rgb_t        light;
  } cd_t;

  // -log2 by repeated squaring
  typedef struct packed {
    logic        vld;
    logic        kill;
    logic [30:0] x;
    logic [23:0] frac;
    logic [4:0]  km;
    rgb_t        light;
  } lg_t;

  // 2^-z as a product of root factors
  typedef struct packed {
    logic        vld;
    logic        kill;
    logic        direct;
    logic [30:0] pd;
    logic [30:0] g;
    logic [23:0] u;
    logic [5:0]  sh;
    rgb_t        light;
  } pw_t;

  typedef logic [30:0] root_tab_t [1:LOG_F];

  function automatic logic [63:0] isqrt_c(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] rem;
    logic [63:0] bit_v;
    res = '0;
    rem = v;
    for (int j = 0; j < 32; j++) begin
      bit_v = 64'd1 << (62 - 2 * j);
      if (rem >= res + bit_v) begin
        rem = rem - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
    end
    return res;
  endfunction

  // 2^(2^-i) in Q.30, each from the previous by an integer square root
  function automatic root_tab_t root_table();
    root_tab_t   t;
    logic [63:0] r;
    r    = isqrt_c(64'd1 << 61);
    t[1] = r[30:0];
    for (int i = 2; i <= LOG_F; i++) begin
      r    = isqrt_c({r[33:0], 30'b0});
      t[i] = r[30:0];
    end
    return t;
  endfunction

  localparam root_tab_t ROOTS = root_table();

endpackage

[rtl/psp_if.sv]
// Stream interfaces of the Phong specular pipeline.
interface psp_in_if #(parameter int VEC_WIDTH = 16);
  logic                        valid;
  logic                        ready;
  logic signed [VEC_WIDTH-1:0] to_light_x;
  logic signed [VEC_WIDTH-1:0] to_light_y;
  logic signed [VEC_WIDTH-1:0] to_light_z;
  logic signed [VEC_WIDTH-1:0] normal_x;
  logic signed [VEC_WIDTH-1:0] normal_y;
  logic signed [VEC_WIDTH-1:0] normal_z;
  logic signed [VEC_WIDTH-1:0] view_x;
  logic signed [VEC_WIDTH-1:0] view_y;
  logic signed [VEC_WIDTH-1:0] view_z;
  logic [15:0]                 light_spec_r;
  logic [15:0]                 light_spec_g;
  logic [15:0]                 light_spec_b;

  modport source (output valid, to_light_x, to_light_y, to_light_z, normal_x, normal_y,
                  normal_z, view_x, view_y, view_z, light_spec_r, light_spec_g,
                  light_spec_b, input ready);
  modport sink (input valid, to_light_x, to_light_y, to_light_z, normal_x, normal_y,
                normal_z, view_x, view_y, view_z, light_spec_r, light_spec_g,
                light_spec_b, output ready);
endinterface

interface psp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_r;
  logic [15:0] out_g;
  logic [15:0] out_b;

  modport source (output valid, out_r, out_g, out_b, input ready);
  modport sink (input valid, out_r, out_g, out_b, output ready);
endinterface

[rtl/psp_vec_scale.sv]
// Three-stage power-of-two normalizer: largest magnitude into [8192, 16384].
module psp_vec_scale #(
  parameter int VEC_WIDTH = 16
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [VEC_WIDTH-1:0] x_i,
  input  logic signed [VEC_WIDTH-1:0] y_i,
  input  logic signed [VEC_WIDTH-1:0] z_i,
  output logic [2:0][15:0]            vec_o,
  output logic                        nz_o
);

  localparam int SW = $clog2(VEC_WIDTH + 1);

  logic [2:0][VEC_WIDTH-1:0] raw;
  logic [2:0][VEC_WIDTH-1:0] mag_d, mag_q, mag2_q;
  logic [2:0]                neg_d, neg_q, neg2_q;
  logic [VEC_WIDTH-1:0]      m_d, m_q;

  int                        p;
  int                        shv;
  logic [33:0]               t1;
  logic                      right_d, right_q;
  logic [SW-1:0]             sh_q;
  logic                      nz2_q;

  logic [2:0][VEC_WIDTH+13:0] ext, sm;
  logic [2:0][14:0]           val;
  logic [2:0][15:0]           vec_d;

  assign raw = {z_i, y_i, x_i};

  // stage 1: magnitudes and their maximum
  always_comb begin
    m_d = '0;
    for (int i = 0; i < 3; i++) begin
      neg_d[i] = raw[i][VEC_WIDTH-1];
      mag_d[i] = neg_d[i] ? (~raw[i] + 1'b1) : raw[i];
      if (mag_d[i] > m_d) m_d = mag_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= mag_d;
      neg_q <= neg_d;
      m_q   <= m_d;
    end
  end

  // stage 2: leading one -> shift direction and amount
  always_comb begin
    p = 0;
    for (int b = 0; b < VEC_WIDTH; b++) begin
      if (m_q[b]) p = b;
    end
    right_d = (34'(m_q) > 34'd16384);
    if (right_d) begin
      t1  = 34'(m_q) >> (p - 14);
      shv = (t1 == 34'd16384) ? p - 14 : p - 13;
    end else begin
      t1  = '0;
      shv = (p < 13) ? 13 - p : 0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag2_q  <= mag_q;
      neg2_q  <= neg_q;
      right_q <= right_d;
      sh_q    <= SW'(shv);
      nz2_q   <= (m_q != '0);
    end
  end

  // stage 3: apply shift, restore sign
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ext[i]   = {14'b0, mag2_q[i]};
      sm[i]    = right_q ? (ext[i] >> sh_q) : (ext[i] << sh_q);
      val[i]   = sm[i][14:0];
      vec_d[i] = neg2_q[i] ? (16'd0 - {1'b0, val[i]}) : {1'b0, val[i]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_o <= vec_d;
      nz_o  <= nz2_q;
    end
  end

endmodule

[rtl/psp_divsqrt_step.sv]
// One bit of the num / |N|^2 divide and one digit of the isqrt, in parallel.
module psp_divsqrt_step import psp_pkg::*; #(
  parameter int STEP = 0
) (
  input  ds_t d_i,
  output ds_t d_o
);

  localparam int B = DS_STEPS - 1 - STEP;

  logic [59:0] dsh;
  logic [59:0] sbit;
  logic [59:0] strial;

  always_comb begin
    d_o    = d_i;
    dsh    = 60'(d_i.dvs) << B;
    sbit   = 60'd1 << (2 * B);
    strial = d_i.sr + sbit;
    if (d_i.rem >= dsh) begin
      d_o.rem  = d_i.rem - dsh;
      d_o.q[B] = 1'b1;
    end
    if (d_i.sv >= strial) begin
      d_o.sv = d_i.sv - strial;
      d_o.sr = (d_i.sr >> 1) + sbit;
    end else begin
      d_o.sr = d_i.sr >> 1;
    end
  end

endmodule

[rtl/psp_cqdiv_step.sv]
// One quotient bit of the cosine divide (t << 30) / D.
module psp_cqdiv_step import psp_pkg::*; #(
  parameter int STEP = 0
) (
  input  cd_t d_i,
  output cd_t d_o
);

  localparam int B = CQ_STEPS - 1 - STEP;

  logic [60:0] dsh;

  always_comb begin
    d_o = d_i;
    dsh = 61'(d_i.dvs) << B;
    if (d_i.rem >= dsh) begin
      d_o.rem  = d_i.rem - dsh;
      d_o.q[B] = 1'b1;
    end
  end

endmodule

[rtl/psp_log_step.sv]
// One fraction bit of log2 by squaring the Q.30 mantissa.
module psp_log_step import psp_pkg::*; #(
  parameter int STEP = 0
) (
  input  lg_t d_i,
  output lg_t d_o
);

  localparam int B = LOG_F - 1 - STEP;

  logic [61:0] sq;
  logic [31:0] y;

  always_comb begin
    d_o = d_i;
    sq  = 62'(d_i.x) * 62'(d_i.x);
    y   = sq[61:30];
    if (y[31]) begin
      d_o.x       = y[31:1];
      d_o.frac[B] = 1'b1;
    end else begin
      d_o.x = y[30:0];
    end
  end

endmodule

[rtl/psp_pow_step.sv]
// One factor 2^(2^-i) of the fractional power, taken when its bit of u is set.
module psp_pow_step import psp_pkg::*; #(
  parameter int STEP = 0
) (
  input  pw_t d_i,
  output pw_t d_o
);

  localparam int I = STEP + 1;

  logic [61:0] prod;

  always_comb begin
    d_o  = d_i;
    prod = 62'(d_i.g) * 62'(ROOTS[I]);
    if (d_i.u[LOG_F-I]) d_o.g = prod[60:30];
  end

endmodule

[rtl/phong_specular_term.sv]
// Top level of the Phong specular pipeline.
//
// Usage: one shading evaluation per transfer on in_i (light direction L,
// normal N, view ray V as signed fixed point, light specular color Q1.15);
// one transfer on out_o per input, in order, with the clamped Q1.15
// specular color. Material color, shininess (Q8.8) and gain (Q4.12) are
// written on the cfg port while no item is in flight.
// Throughput: one transfer per cycle while the skid entry is empty.
// Bit-serial stages: 30 for num/|N|^2 and the norm isqrt, 31 for the
// cosine divide, 24 for the log squarings, 24 for the power factors.
// Reset: all valid bits clear, config registers take their default values.
// Stall: out_o has an output register plus one skid entry. When the skid
// entry fills, the whole pipeline freezes and in_i.ready drops with it;
// nothing is lost or repeated.
module phong_specular_term import psp_pkg::*; #(
  parameter int VEC_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  psp_in_if.sink      in_i,
  psp_out_if.source   out_o
);

  // ---------------- configuration registers ----------------
  rgb_t        mat_q;
  logic [15:0] shin_q;
  logic [15:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q  <= '0;
      shin_q <= 16'd256;
      gain_q <= 16'd4096;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAT_R:     mat_q[0] <= cfg_data_i;
        REG_MAT_G:     mat_q[1] <= cfg_data_i;
        REG_MAT_B:     mat_q[2] <= cfg_data_i;
        REG_SHININESS: shin_q   <= cfg_data_i;
        REG_SPEC_GAIN: gain_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- global stall ----------------
  logic en;
  logic sv_q;  // skid entry occupied
  assign en         = ~sv_q;
  assign in_i.ready = en;

  // ---------------- front: vector normalize (3 stages) ----------------
  logic [2:0] fvld_q;
  rgb_t       flight_q [3];
  logic [2:0][15:0] lvec, nvec, vvec;
  logic nzl, nzn, nzv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fvld_q <= '0;
    else if (en) fvld_q <= {fvld_q[1:0], in_i.valid};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      flight_q[0] <= {in_i.light_spec_b, in_i.light_spec_g, in_i.light_spec_r};
      flight_q[1] <= flight_q[0];
      flight_q[2] <= flight_q[1];
    end
  end

  psp_vec_scale #(.VEC_WIDTH(VEC_WIDTH)) u_scale_l (
    .clk_i, .en_i(en), .x_i(in_i.to_light_x), .y_i(in_i.to_light_y),
    .z_i(in_i.to_light_z), .vec_o(lvec), .nz_o(nzl)
  );
  psp_vec_scale #(.VEC_WIDTH(VEC_WIDTH)) u_scale_n (
    .clk_i, .en_i(en), .x_i(in_i.normal_x), .y_i(in_i.normal_y),
    .z_i(in_i.normal_z), .vec_o(nvec), .nz_o(nzn)
  );
  psp_vec_scale #(.VEC_WIDTH(VEC_WIDTH)) u_scale_v (
    .clk_i, .en_i(en), .x_i(in_i.view_x), .y_i(in_i.view_y),
    .z_i(in_i.view_z), .vec_o(vvec), .nz_o(nzv)
  );

  // ---------------- dot products ----------------
  logic               p_vld_q, p_ok_q;
  rgb_t               p_light_q;
  logic signed [31:0] lv_q [3], ln_q [3], nv_q [3], nn_q [3], ll_q [3], vv_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p_vld_q <= 1'b0;
    else if (en) p_vld_q <= fvld_q[2];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_ok_q    <= nzl & nzn & nzv;
      p_light_q <= flight_q[2];
      for (int i = 0; i < 3; i++) begin
        lv_q[i] <= $signed(lvec[i]) * $signed(vvec[i]);
        ln_q[i] <= $signed(lvec[i]) * $signed(nvec[i]);
        nv_q[i] <= $signed(nvec[i]) * $signed(vvec[i]);
        nn_q[i] <= $signed(nvec[i]) * $signed(nvec[i]);
        ll_q[i] <= $signed(lvec[i]) * $signed(lvec[i]);
        vv_q[i] <= $signed(vvec[i]) * $signed(vvec[i]);
      end
    end
  end

  logic               d_vld_q, d_ok_q;
  rgb_t               d_light_q;
  logic signed [31:0] d_lv_q, d_ln_q, d_nv_q, d_nn_q, d_ll_q, d_vv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d_vld_q <= 1'b0;
    else if (en) d_vld_q <= p_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_ok_q    <= p_ok_q;
      d_light_q <= p_light_q;
      d_lv_q    <= lv_q[0] + lv_q[1] + lv_q[2];
      d_ln_q    <= ln_q[0] + ln_q[1] + ln_q[2];
      d_nv_q    <= nv_q[0] + nv_q[1] + nv_q[2];
      d_nn_q    <= nn_q[0] + nn_q[1] + nn_q[2];
      d_ll_q    <= ll_q[0] + ll_q[1] + ll_q[2];
      d_vv_q    <= vv_q[0] + vv_q[1] + vv_q[2];
    end
  end

  // ---------------- num terms and |L|^2|V|^2 ----------------
  logic               m_vld_q, m_ok_q;
  rgb_t               m_light_q;
  logic signed [63:0] m_p1_q, m_p2_q;
  logic [63:0]        m_llvv_q;
  logic [29:0]        m_nn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_vld_q <= 1'b0;
    else if (en) m_vld_q <= d_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_ok_q    <= d_ok_q;
      m_light_q <= d_light_q;
      m_p1_q    <= d_nn_q * d_lv_q;
      m_p2_q    <= d_ln_q * d_nv_q;
      m_llvv_q  <= 64'($unsigned(d_ll_q)) * 64'($unsigned(d_vv_q));
      m_nn_q    <= d_nn_q[29:0];
    end
  end

  // num = |N|^2 (L.V) - 2 (L.N)(N.V); c > 0 iff num > 0
  logic signed [63:0] num;
  ds_t                ds0_d;

  always_comb begin
    num         = m_p1_q - (m_p2_q <<< 1);
    ds0_d.vld   = m_vld_q;
    ds0_d.kill  = ~m_ok_q | num[63] | (num == '0);
    ds0_d.rem   = num[59:0];
    ds0_d.dvs   = m_nn_q;
    ds0_d.q     = '0;
    ds0_d.sv    = m_llvv_q[59:0];
    ds0_d.sr    = '0;
    ds0_d.light = m_light_q;
  end

  // ---------------- t = num / A and D = isqrt ----------------
  ds_t ds_q [DS_STEPS+1];
  ds_t ds_d [DS_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ds_q[0].vld <= 1'b0;
    else if (en) ds_q[0] <= ds0_d;
  end

  for (genvar k = 0; k < DS_STEPS; k++) begin : g_ds
    psp_divsqrt_step #(.STEP(k)) u_step (.d_i(ds_q[k]), .d_o(ds_d[k]));
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) ds_q[k+1].vld <= 1'b0;
      else if (en) ds_q[k+1] <= ds_d[k];
    end
  end

  // ---------------- cq = (t << 30) / D ----------------
  cd_t cd0_d;
  cd_t cd_q [CQ_STEPS+1];
  cd_t cd_d [CQ_STEPS];

  always_comb begin
    cd0_d.vld   = ds_q[DS_STEPS].vld;
    cd0_d.kill  = ds_q[DS_STEPS].kill;
    cd0_d.rem   = 61'({ds_q[DS_STEPS].q, 30'b0});
    cd0_d.dvs   = ds_q[DS_STEPS].sr[29:0];
    // quotient of 2^31 or more: clamps to 1.0 anyway
    cd0_d.sat   = ({1'b0, ds_q[DS_STEPS].q} >= {ds_q[DS_STEPS].sr[29:0], 1'b0});
    cd0_d.q     = '0;
    cd0_d.light = ds_q[DS_STEPS].light;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cd_q[0].vld <= 1'b0;
    else if (en) cd_q[0] <= cd0_d;
  end

  for (genvar k = 0; k < CQ_STEPS; k++) begin : g_cd
    psp_cqdiv_step #(.STEP(k)) u_step (.d_i(cd_q[k]), .d_o(cd_d[k]));
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) cd_q[k+1].vld <= 1'b0;
      else if (en) cd_q[k+1] <= cd_d[k];
    end
  end

  // ---------------- -log2(cq): normalize, then squarings ----------------
  logic [30:0] cq;
  int          lead;
  lg_t         lg0_d;
  lg_t         lg_q [LOG_STEPS+1];
  lg_t         lg_d [LOG_STEPS];

  always_comb begin
    cq = (cd_q[CQ_STEPS].sat | cd_q[CQ_STEPS].q[30]) ? ONE30 : cd_q[CQ_STEPS].q;
    lead = 0;
    for (int b = 0; b < 31; b++) begin
      if (cq[b]) lead = b;
    end
    lg0_d.vld   = cd_q[CQ_STEPS].vld;
    lg0_d.kill  = cd_q[CQ_STEPS].kill | (cq == '0);
    lg0_d.x     = cq << (30 - lead);
    lg0_d.frac  = '0;
    lg0_d.km    = 5'(30 - lead);
    lg0_d.light = cd_q[CQ_STEPS].light;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) lg_q[0].vld <= 1'b0;
    else if (en) lg_q[0] <= lg0_d;
  end

  for (genvar k = 0; k < LOG_STEPS; k++) begin : g_lg
    psp_log_step #(.STEP(k)) u_step (.d_i(lg_q[k]), .d_o(lg_d[k]));
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) lg_q[k+1].vld <= 1'b0;
      else if (en) lg_q[k+1] <= lg_d[k];
    end
  end

  // ---------------- z = e * shininess ----------------
  logic        e1_vld_q, e1_kill_q;
  rgb_t        e1_light_q;
  logic [28:0] e1_q;
  logic        e2_vld_q, e2_kill_q;
  rgb_t        e2_light_q;
  logic [44:0] zprod;
  logic [36:0] e2_z_q;

  assign zprod = 45'(e1_q) * 45'(shin_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_vld_q <= 1'b0;
      e2_vld_q <= 1'b0;
    end else if (en) begin
      e1_vld_q <= lg_q[LOG_STEPS].vld;
      e2_vld_q <= e1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_kill_q  <= lg_q[LOG_STEPS].kill;
      e1_light_q <= lg_q[LOG_STEPS].light;
      e1_q       <= {lg_q[LOG_STEPS].km, 24'b0} - 29'(lg_q[LOG_STEPS].frac);
      e2_kill_q  <= e1_kill_q;
      e2_light_q <= e1_light_q;
      e2_z_q     <= zprod[44:8];
    end
  end

  // ---------------- p = 2^-z ----------------
  logic [12:0] zi;
  logic [23:0] zf;
  pw_t         pw0_d;
  pw_t         pw_q [POW_STEPS+1];
  pw_t         pw_d [POW_STEPS];

  always_comb begin
    zi           = e2_z_q[36:24];
    zf           = e2_z_q[23:0];
    pw0_d.vld    = e2_vld_q;
    pw0_d.kill   = e2_kill_q;
    pw0_d.g      = ONE30;
    pw0_d.u      = ~zf + 24'd1;
    pw0_d.sh     = 6'(zi + 13'd1);
    pw0_d.light  = e2_light_q;
    pw0_d.direct = 1'b0;
    pw0_d.pd     = '0;
    if (zf == '0) begin
      // whole exponent: plain shift of 1.0
      pw0_d.direct = 1'b1;
      pw0_d.pd     = (zi >= 13'd40) ? '0 : (ONE30 >> zi);
    end else if (zi + 13'd1 >= 13'd40) begin
      pw0_d.direct = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pw_q[0].vld <= 1'b0;
    else if (en) pw_q[0] <= pw0_d;
  end

  for (genvar k = 0; k < POW_STEPS; k++) begin : g_pw
    psp_pow_step #(.STEP(k)) u_step (.d_i(pw_q[k]), .d_o(pw_d[k]));
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) pw_q[k+1].vld <= 1'b0;
      else if (en) pw_q[k+1] <= pw_d[k];
    end
  end

  // ---------------- color channels ----------------
  logic                c0_vld_q, c1_vld_q, c2_vld_q, c3_vld_q;
  rgb_t                c0_light_q;
  logic [30:0]         c0_pw_q, c1_pw_q;
  logic [30:0]         pw_fin;
  logic [2:0][31:0]    c1_lm_q;
  logic [2:0][32:0]    c2_v_q;
  logic [2:0][36:0]    c3_v_q;
  logic [2:0][62:0]    vp;
  logic [2:0][48:0]    gp;

  always_comb begin
    if (pw_q[POW_STEPS].kill) pw_fin = '0;
    else if (pw_q[POW_STEPS].direct) pw_fin = pw_q[POW_STEPS].pd;
    else pw_fin = pw_q[POW_STEPS].g >> pw_q[POW_STEPS].sh;
    for (int c = 0; c < 3; c++) begin
      vp[c] = 63'(c1_lm_q[c]) * 63'(c1_pw_q);
      gp[c] = 49'(c2_v_q[c]) * 49'(gain_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c0_vld_q <= 1'b0;
      c1_vld_q <= 1'b0;
      c2_vld_q <= 1'b0;
      c3_vld_q <= 1'b0;
    end else if (en) begin
      c0_vld_q <= pw_q[POW_STEPS].vld;
      c1_vld_q <= c0_vld_q;
      c2_vld_q <= c1_vld_q;
      c3_vld_q <= c2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c0_pw_q    <= pw_fin;
      c0_light_q <= pw_q[POW_STEPS].light;
      c1_pw_q    <= c0_pw_q;
      for (int c = 0; c < 3; c++) begin
        c1_lm_q[c] <= 32'(c0_light_q[c]) * 32'(mat_q[c]);
        c2_v_q[c]  <= vp[c][62:30];
        c3_v_q[c]  <= gp[c][48:12];
      end
    end
  end

  // final clamp to 1.0
  rgb_t res;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      res[c] = (c3_v_q[c][36:15] > 22'd32768) ? 16'd32768 : c3_v_q[c][30:15];
    end
  end

  // ---------------- output register and skid entry ----------------
  logic ov_q;
  rgb_t od_q, sd_q;
  logic push, pop;

  assign push = en & c3_vld_q;
  assign pop  = ov_q & out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (pop || !ov_q) begin
      if (sv_q) begin
        ov_q <= 1'b1;
        sv_q <= 1'b0;
      end else begin
        ov_q <= push;
      end
    end else if (push) begin
      sv_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop || !ov_q) begin
      if (sv_q) od_q <= sd_q;
      else if (push) od_q <= res;
    end else if (push) begin
      sd_q <= res;
    end
  end

  assign out_o.valid = ov_q;
  assign out_o.out_r = od_q[0];
  assign out_o.out_g = od_q[1];
  assign out_o.out_b = od_q[2];

  // ---------------- assertions ----------------
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q |-> ov_q)
    else $error("skid entry holds data while output register is empty");

  a_stall_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_o.ready && push) |=> sv_q)
    else $error("result arriving during a stall was not parked in skid entry");

  a_out_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (od_q[0] <= 16'd32768 && od_q[1] <= 16'd32768 && od_q[2] <= 16'd32768))
    else $error("output channel above 1.0");

endmodule
